// ----- rtl/core/scdg_pkg.sv -----
// Shared constants, widths and tables for the sine/cosine disturbance generator.
package scdg_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int FRACTION_BITS = 16;

  localparam int TS_W   = 32;
  localparam int AMP_W  = 18;
  localparam int FREQ_W = 24;
  localparam int OFFS_W = 16;
  localparam int POS_W  = 19;
  localparam int VEL_W  = 30;
  localparam int CFG_W  = 24;
  localparam int IDX_W  = 2;

  // CORDIC x/y carry FRACTION_BITS fraction bits plus headroom for gain and sign
  localparam int XY_W = FRACTION_BITS + 3;
  localparam int Z_W  = 32;
  // amplitude * frequency * 2pi, scaled by 2^-8, with 2pi in Q.24
  localparam int W_W  = 37;

  localparam int POS_LIMIT = 262143;
  localparam int VEL_LIMIT = 536870911;

  localparam logic [26:0] TWO_PI_Q24 = 27'd105414357;

  localparam logic [63:0] GAIN_Q32 = 64'd2608131496;
  localparam logic [63:0] GAIN_XY  =
    (GAIN_Q32 + (64'd1 << (31 - FRACTION_BITS))) >> (32 - FRACTION_BITS);

  // atan(2^-i) in Q0.32 turns
  localparam logic [31:0] ATAN_TURNS [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // two phase stages, CORDIC load, iterations, quadrant fold, multiply, round
  localparam int LATENCY = CORDIC_STAGES + 6;

  typedef enum logic [IDX_W-1:0] {
    CFG_AMPLITUDE = 2'd0,
    CFG_FREQUENCY = 2'd1,
    CFG_PHASE_OFS = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_t;

endpackage

// ----- rtl/core/scdg_phase.sv -----
// Phase accumulation stages: time times frequency, plus phase offset, in Q0.32 turns.
module scdg_phase (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [scdg_pkg::TS_W-1:0]       time_stamp,
  input  logic [scdg_pkg::FREQ_W-1:0]     frequency_hz,
  input  logic [scdg_pkg::OFFS_W-1:0]     offset_turns,
  output logic                            out_valid,
  output logic [31:0]                     phase
);

  // only the fractional turns matter, so the product is kept modulo 2^32
  logic [31:0]       prod_low;
  logic [31:0]       prod_r;
  logic [31:0]       phase_r;
  logic              v1_r;
  logic              v2_r;

  assign prod_low = time_stamp * 32'(frequency_hz);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
    prod_r  <= prod_low;
    phase_r <= prod_r + {offset_turns, 16'd0};
  end

  assign out_valid = v2_r;
  assign phase     = phase_r;

endmodule

// ----- rtl/core/scdg_cordic.sv -----
// Unrolled rotation-mode CORDIC, one iteration per register stage, with quadrant fold.
module scdg_cordic (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [31:0]                         phase,
  output logic                                out_valid,
  output logic signed [scdg_pkg::XY_W-1:0]    sin_val,
  output logic signed [scdg_pkg::XY_W-1:0]    cos_val
);

  localparam int N    = scdg_pkg::CORDIC_STAGES;
  localparam int XY_W = scdg_pkg::XY_W;
  localparam int Z_W  = scdg_pkg::Z_W;

  logic signed [XY_W-1:0] x_r [N+1];
  logic signed [XY_W-1:0] y_r [N+1];
  logic signed [Z_W-1:0]  z_r [N+1];
  logic [1:0]             quad_r [N+1];
  logic                   v_r [N+1];

  logic signed [XY_W-1:0] sin_r;
  logic signed [XY_W-1:0] cos_r;
  logic                   vo_r;

  // load: residual angle is the low 30 phase bits, never negative
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
    x_r[0]    <= XY_W'(scdg_pkg::GAIN_XY);
    y_r[0]    <= '0;
    z_r[0]    <= $signed({2'b00, phase[29:0]});
    quad_r[0] <= phase[31:30];
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  da;

    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    assign da = $signed(scdg_pkg::ATAN_TURNS[i]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else begin
        v_r[i+1] <= v_r[i];
      end
      if (!z_r[i][Z_W-1]) begin
        x_r[i+1] <= x_r[i] - dx;
        y_r[i+1] <= y_r[i] + dy;
        z_r[i+1] <= z_r[i] - da;
      end else begin
        x_r[i+1] <= x_r[i] + dx;
        y_r[i+1] <= y_r[i] - dy;
        z_r[i+1] <= z_r[i] + da;
      end
      quad_r[i+1] <= quad_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= v_r[N];
    end
    case (quad_r[N])
      2'd0: begin
        sin_r <= y_r[N];
        cos_r <= x_r[N];
      end
      2'd1: begin
        sin_r <= x_r[N];
        cos_r <= -y_r[N];
      end
      2'd2: begin
        sin_r <= -y_r[N];
        cos_r <= -x_r[N];
      end
      default: begin
        sin_r <= -x_r[N];
        cos_r <= y_r[N];
      end
    endcase
  end

  assign out_valid = vo_r;
  assign sin_val   = sin_r;
  assign cos_val   = cos_r;

endmodule

// ----- rtl/core/scdg_scale.sv -----
// Output scaling: amplitude and angular-rate multiplies, rounding and saturation.
module scdg_scale (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [scdg_pkg::AMP_W-1:0]         amplitude,
  input  logic [scdg_pkg::FREQ_W-1:0]        frequency_hz,
  input  logic                               in_valid,
  input  logic signed [scdg_pkg::XY_W-1:0]   sin_val,
  input  logic signed [scdg_pkg::XY_W-1:0]   cos_val,
  output logic                               out_valid,
  output logic signed [scdg_pkg::POS_W-1:0]  position,
  output logic signed [scdg_pkg::VEL_W-1:0]  velocity
);

  localparam int F     = scdg_pkg::FRACTION_BITS;
  localparam int XY_W  = scdg_pkg::XY_W;
  localparam int W_W   = scdg_pkg::W_W;
  localparam int M_W   = scdg_pkg::AMP_W + scdg_pkg::FREQ_W;
  localparam int M8_W  = M_W - 8;
  localparam int WP_W  = M8_W + 27;
  localparam int PP_W  = scdg_pkg::AMP_W + 1 + XY_W;
  localparam int VP_W  = W_W + 1 + XY_W;

  localparam logic signed [PP_W-1:0] POS_HI = PP_W'(scdg_pkg::POS_LIMIT);
  localparam logic signed [PP_W-1:0] POS_LO = -POS_HI;
  localparam logic signed [VP_W-1:0] VEL_HI = VP_W'(scdg_pkg::VEL_LIMIT);
  localparam logic signed [VP_W-1:0] VEL_LO = -VEL_HI;

  // angular-rate term follows the configuration registers only, through m_r, m8_r and wp_r
  logic [M_W-1:0]   m_r;
  logic [M8_W-1:0]  m8_r;
  logic [WP_W-1:0]  wp_r;
  logic [M_W:0]     m_rnd;
  logic [WP_W:0]    wp_rnd;
  logic [W_W-1:0]   w;

  assign m_rnd  = {1'b0, m_r} + (M_W+1)'(128);
  assign wp_rnd = {1'b0, wp_r} + (WP_W+1)'(1 << 23);
  assign w      = wp_rnd[24 +: W_W];

  always_ff @(posedge clk) begin
    m_r  <= M_W'(amplitude) * M_W'(frequency_hz);
    m8_r <= m_rnd[8 +: M8_W];
    wp_r <= WP_W'(m8_r) * WP_W'(scdg_pkg::TWO_PI_Q24);
  end

  logic signed [PP_W-1:0] pos_prod_r;
  logic signed [VP_W-1:0] vel_prod_r;
  logic                   vm_r;
  logic signed [PP_W-1:0] pos_rnd;
  logic signed [VP_W-1:0] vel_rnd;
  logic signed [scdg_pkg::POS_W-1:0] pos_nxt;
  logic signed [scdg_pkg::VEL_W-1:0] vel_nxt;
  logic signed [scdg_pkg::POS_W-1:0] pos_r;
  logic signed [scdg_pkg::VEL_W-1:0] vel_r;
  logic                   vo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      vm_r <= in_valid;
      vo_r <= vm_r;
    end
    pos_prod_r <= PP_W'($signed({1'b0, amplitude})) * PP_W'(sin_val);
    vel_prod_r <= VP_W'($signed({1'b0, w})) * VP_W'(cos_val);
    pos_r      <= pos_nxt;
    vel_r      <= vel_nxt;
  end

  assign pos_rnd = (pos_prod_r + (PP_W'(1) <<< (F - 1))) >>> F;
  assign vel_rnd = (vel_prod_r + (VP_W'(1) <<< (F + 7))) >>> (F + 8);

  always_comb begin
    if (pos_rnd > POS_HI) begin
      pos_nxt = POS_HI[scdg_pkg::POS_W-1:0];
    end else if (pos_rnd < POS_LO) begin
      pos_nxt = POS_LO[scdg_pkg::POS_W-1:0];
    end else begin
      pos_nxt = pos_rnd[scdg_pkg::POS_W-1:0];
    end
    if (vel_rnd > VEL_HI) begin
      vel_nxt = VEL_HI[scdg_pkg::VEL_W-1:0];
    end else if (vel_rnd < VEL_LO) begin
      vel_nxt = VEL_LO[scdg_pkg::VEL_W-1:0];
    end else begin
      vel_nxt = vel_rnd[scdg_pkg::VEL_W-1:0];
    end
  end

  assign out_valid = vo_r;
  assign position  = pos_r;
  assign velocity  = vel_r;

endmodule

// ----- rtl/core/sine_cosine_disturbance_generator.sv -----
// Top level: configuration registers, phase, CORDIC and scaling pipeline.
//
// Sinusoidal disturbance generator. Each time stamp transfer (start high while busy is
// low) yields exactly one result, presented for a single cycle with out_valid; the
// pipeline depth is set by the one-iteration-per-stage CORDIC. A new time stamp may be
// taken every cycle, busy stays low and results cannot be held off, so the receiver
// must take every strobe. Configuration writes are always ready; change them only
// while no item is in flight.
module sine_cosine_disturbance_generator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [scdg_pkg::TS_W-1:0]          in_time_stamp,
  output logic                               out_valid,
  output logic signed [scdg_pkg::POS_W-1:0]  out_position,
  output logic signed [scdg_pkg::VEL_W-1:0]  out_velocity,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [scdg_pkg::IDX_W-1:0]         cfg_index,
  input  logic [scdg_pkg::CFG_W-1:0]         cfg_data
);

  logic [scdg_pkg::AMP_W-1:0]  amp_r;
  logic [scdg_pkg::FREQ_W-1:0] freq_r;
  logic [scdg_pkg::OFFS_W-1:0] offs_r;

  logic                                  ph_valid;
  logic [31:0]                           phase;
  logic                                  cs_valid;
  logic signed [scdg_pkg::XY_W-1:0]      sin_val;
  logic signed [scdg_pkg::XY_W-1:0]      cos_val;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r  <= scdg_pkg::AMP_W'(3277);
      freq_r <= scdg_pkg::FREQ_W'(327680);
      offs_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (scdg_pkg::cfg_idx_t'(cfg_index))
        scdg_pkg::CFG_AMPLITUDE: amp_r  <= cfg_data[scdg_pkg::AMP_W-1:0];
        scdg_pkg::CFG_FREQUENCY: freq_r <= cfg_data[scdg_pkg::FREQ_W-1:0];
        scdg_pkg::CFG_PHASE_OFS: offs_r <= cfg_data[scdg_pkg::OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  scdg_phase u_phase (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (start && !busy),
    .time_stamp   (in_time_stamp),
    .frequency_hz (freq_r),
    .offset_turns (offs_r),
    .out_valid    (ph_valid),
    .phase        (phase)
  );

  scdg_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ph_valid),
    .phase     (phase),
    .out_valid (cs_valid),
    .sin_val   (sin_val),
    .cos_val   (cos_val)
  );

  scdg_scale u_scale (
    .clk          (clk),
    .rst_n        (rst_n),
    .amplitude    (amp_r),
    .frequency_hz (freq_r),
    .in_valid     (cs_valid),
    .sin_val      (sin_val),
    .cos_val      (cos_val),
    .out_valid    (out_valid),
    .position     (out_position),
    .velocity     (out_velocity)
  );

  // every accepted time stamp comes out after the fixed pipeline depth
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(scdg_pkg::LATENCY) out_valid)
    else $error("result missing after pipeline latency");

  // saturation keeps both fields symmetric, the most negative codes never appear
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_position != {1'b1, {(scdg_pkg::POS_W-1){1'b0}}}) &&
                  (out_velocity != {1'b1, {(scdg_pkg::VEL_W-1){1'b0}}}))
    else $error("result outside saturation range");

endmodule

// ----- tb/sine_cosine_disturbance_generator_test.sv -----
// Self-checking testbench for the sine/cosine disturbance generator, with its own scoreboard.
module sine_cosine_disturbance_generator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TS_W          = scdg_pkg::TS_W;
  localparam int AMP_W         = scdg_pkg::AMP_W;
  localparam int FREQ_W        = scdg_pkg::FREQ_W;
  localparam int OFFS_W        = scdg_pkg::OFFS_W;
  localparam int POS_W         = scdg_pkg::POS_W;
  localparam int VEL_W         = scdg_pkg::VEL_W;
  localparam int CFG_W         = scdg_pkg::CFG_W;
  localparam int IDX_W         = scdg_pkg::IDX_W;
  localparam int CORDIC_STAGES = scdg_pkg::CORDIC_STAGES;
  localparam int FRACTION_BITS = scdg_pkg::FRACTION_BITS;
  localparam int LATENCY       = scdg_pkg::LATENCY;

  typedef scdg_pkg::cfg_idx_t cfg_idx_t;

  localparam int STALL_LIMIT    = 1000;
  localparam int REPORT_LIMIT   = 10;
  localparam int RANDOM_PHASES  = 13;
  localparam int ITEMS_PER_PHASE = 150;

  // rotation angles atan(2^-i), Q0.32 turns
  localparam logic [31:0] ROT_ANGLE [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };
  localparam longint unsigned CORDIC_GAIN_Q32 = 64'd2608131496;
  localparam longint unsigned TWO_PI_Q3_24    = 64'd105414357;
  localparam longint POSITION_MAX = 262143;
  localparam longint VELOCITY_MAX = 536870911;

  typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quadrant_t;

  typedef struct {
    logic [TS_W-1:0]         time_stamp;
    logic signed [POS_W-1:0] position;
    logic signed [VEL_W-1:0] velocity;
  } wave_sample_t;

  class DisturbanceScoreboard;
    logic [AMP_W-1:0]  amplitude;
    logic [FREQ_W-1:0] frequency;
    logic [OFFS_W-1:0] turn_offset;
    wave_sample_t      expected_samples[$];
    int                errors;

    function void restore_regs();
      amplitude   = AMP_W'(3277);
      frequency   = FREQ_W'(327680);
      turn_offset = '0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
      case (idx)
        scdg_pkg::CFG_AMPLITUDE: amplitude   = data[AMP_W-1:0];
        scdg_pkg::CFG_FREQUENCY: frequency   = data[FREQ_W-1:0];
        scdg_pkg::CFG_PHASE_OFS: turn_offset = data[OFFS_W-1:0];
        default: ;
      endcase
    endfunction

    function longint saturate(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function wave_sample_t predict_sample(logic [TS_W-1:0] ts);
      logic [63:0]       product;
      logic [31:0]       phase;
      quadrant_t         quad;
      longint            x, y, z, dx, dy, sine, cosine, pos, vel;
      longint unsigned   m, m8, w;
      wave_sample_t      smp;
      product = 64'(ts) * 64'(frequency);
      phase   = product[31:0] + {turn_offset, 16'h0000};
      quad    = quadrant_t'(phase[31:30]);
      z = longint'(phase[29:0]);
      x = longint'((CORDIC_GAIN_Q32 + (64'd1 << (31 - FRACTION_BITS))) >> (32 - FRACTION_BITS));
      y = 0;
      for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx; y = y + dy; z = z - longint'(ROT_ANGLE[i]);
        end else begin
          x = x + dx; y = y - dy; z = z + longint'(ROT_ANGLE[i]);
        end
      end
      case (quad)
        QUAD_I:   begin sine = y;  cosine = x;  end
        QUAD_II:  begin sine = x;  cosine = -y; end
        QUAD_III: begin sine = -y; cosine = -x; end
        default:  begin sine = -x; cosine = y;  end
      endcase
      pos = (longint'(amplitude) * sine + (longint'(1) << (FRACTION_BITS - 1)))
            >>> FRACTION_BITS;
      pos = saturate(pos, POSITION_MAX);
      m   = longint'(amplitude) * longint'(frequency);
      m8  = (m + 64'd128) >> 8;
      w   = (m8 * TWO_PI_Q3_24 + (64'd1 << 23)) >> 24;
      vel = (longint'(w) * cosine + (longint'(1) << (FRACTION_BITS + 7)))
            >>> (FRACTION_BITS + 8);
      vel = saturate(vel, VELOCITY_MAX);
      smp.time_stamp = ts;
      smp.position   = POS_W'(pos);
      smp.velocity   = VEL_W'(vel);
      return smp;
    endfunction

    function void note_time_stamp(logic [TS_W-1:0] ts);
      expected_samples.push_back(predict_sample(ts));
    endfunction

    function void check_sample(logic signed [POS_W-1:0] pos, logic signed [VEL_W-1:0] vel);
      wave_sample_t exp_smp;
      if (expected_samples.size() == 0) begin
        if (errors < REPORT_LIMIT)
          $display("unexpected result: position %0d velocity %0d", pos, vel);
        errors++;
        return;
      end
      exp_smp = expected_samples.pop_front();
      if (pos !== exp_smp.position || vel !== exp_smp.velocity) begin
        if (errors < REPORT_LIMIT)
          $display("mismatch at time stamp %h: position exp %0d got %0d, velocity exp %0d got %0d",
                   exp_smp.time_stamp, exp_smp.position, pos, exp_smp.velocity, vel);
        errors++;
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction

    function void close_out();
      if (expected_samples.size() != 0) begin
        if (errors < REPORT_LIMIT)
          $display("%0d results never arrived", expected_samples.size());
        errors += expected_samples.size();
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [TS_W-1:0]         in_time_stamp = '0;
  logic                    out_valid;
  logic signed [POS_W-1:0] out_position;
  logic signed [VEL_W-1:0] out_velocity;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [IDX_W-1:0]        cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;

  DisturbanceScoreboard sb;
  int idle_cycles = 0;

  sine_cosine_disturbance_generator i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_time_stamp (in_time_stamp),
    .out_valid     (out_valid),
    .out_position  (out_position),
    .out_velocity  (out_velocity),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_sample(out_position, out_velocity);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || (cfg_valid && cfg_ready) || out_valid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // start is left high so the next call can follow back to back
  task automatic send_time_stamp(input logic [TS_W-1:0] ts);
    start         <= 1'b1;
    in_time_stamp <= ts;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_time_stamp(ts);
  endtask

  task automatic hold_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_cfg_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return CFG_W'($urandom_range(0, 24'h0A0000));
      default: return CFG_W'($urandom);
    endcase
  endfunction

  function automatic logic [TS_W-1:0] pick_time_stamp();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 16'hFFFF);
      1:       return {12'h000, 20'($urandom)};
      2:       return 32'hFFFF_FFFF - $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [TS_W-1:0]   reset_stamps [7];
    logic [TS_W-1:0]   sat_stamps [4];
    logic [OFFS_W-1:0] quadrant_offsets [5];
    int sent, burst;
    bit steady;

    sb = new();
    sb.restore_regs();
    reset_stamps = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0CCD, 32'h0000_199A,
                     32'h0000_3333, 32'h8000_0000, 32'hFFFF_FFFF};
    sat_stamps = '{32'h0000_0000, 32'h0000_4000, 32'hFFFF_FFFF, 32'h1234_5678};
    quadrant_offsets = '{16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h2000};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register values straight out of reset
    foreach (reset_stamps[i]) send_time_stamp(reset_stamps[i]);
    drain_results();

    // stray high bits on amplitude, full-scale frequency
    write_cfg(scdg_pkg::CFG_AMPLITUDE, 24'hFF_FFFF);
    write_cfg(scdg_pkg::CFG_FREQUENCY, 24'hFF_FFFF);
    write_cfg(scdg_pkg::CFG_PHASE_OFS, 24'h00_0000);
    foreach (sat_stamps[i]) send_time_stamp(sat_stamps[i]);
    drain_results();

    // frequency zero, so the offset alone picks the quadrant; unused index is ignored
    write_cfg(scdg_pkg::CFG_FREQUENCY, 24'h00_0000);
    write_cfg(scdg_pkg::CFG_UNUSED, 24'hFF_FFFF);
    foreach (quadrant_offsets[i]) begin
      write_cfg(scdg_pkg::CFG_PHASE_OFS, {8'hAB, quadrant_offsets[i]});
      send_time_stamp($urandom);
      drain_results();
    end

    write_cfg(scdg_pkg::CFG_AMPLITUDE, 24'h00_0000);
    write_cfg(scdg_pkg::CFG_FREQUENCY, 24'h01_0000);
    send_time_stamp(32'h0000_4000);
    send_time_stamp(32'hDEAD_BEEF);
    drain_results();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_cfg(scdg_pkg::CFG_AMPLITUDE, pick_cfg_value());
      write_cfg(scdg_pkg::CFG_FREQUENCY, pick_cfg_value());
      write_cfg(scdg_pkg::CFG_PHASE_OFS, pick_cfg_value());
      if ($urandom_range(0, 2) == 0)
        write_cfg(scdg_pkg::CFG_UNUSED, CFG_W'($urandom));
      steady = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        burst = $urandom_range(1, 40);
        for (int b = 0; b < burst && sent < ITEMS_PER_PHASE; b++) begin
          send_time_stamp(pick_time_stamp());
          sent++;
        end
        if (!steady && sent < ITEMS_PER_PHASE && $urandom_range(0, 3) != 0)
          hold_sender($urandom_range(1, 8));
      end
      drain_results();
    end

    repeat (LATENCY + 4) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
